/* hdl/h264_rtp_packetizer_macros.svh */
// Assertion macros for the H.264 RTP packetizer checker.
// Needs a clock named clk and an active-low reset named arst_n where used.
`ifndef H264_RTP_PACKETIZER_MACROS_SVH
`define H264_RTP_PACKETIZER_MACROS_SVH

// Property that holds at the same edge as its trigger.
`define RTP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Property that holds at the edge after its trigger.
`define RTP_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

/* hdl/h264rtp_pkg.sv */
// Shared types and constants of the H.264 RTP packetizer.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package h264rtp_pkg;

	localparam int DEF_BUFFER_BYTES  = 65536;
	localparam int DEF_MAX_FRAGMENTS = 64;

	localparam int MP_W     = 11;
	localparam int PT_W     = 7;
	localparam int SSRC_W   = 32;
	localparam int TS_W     = 32;
	localparam int BYTE_W   = 8;
	localparam int OFF_W    = 16;
	localparam int LEN_W    = 11;
	localparam int SEQ_W    = 16;

	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 144;
	localparam int OUT_TUSER_W = 2;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_PAYLOAD  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_PAYLOAD_TYPE = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_STREAM_SSRC  = 2'd2;

	localparam logic [MP_W-1:0]   MP_RESET   = 11'd1400;
	localparam logic [MP_W-1:0]   MP_MIN     = 11'd16;
	localparam logic [MP_W-1:0]   MP_MAX     = 11'd1500;
	localparam logic [PT_W-1:0]   PT_RESET   = 7'd96;
	localparam logic [SSRC_W-1:0] SSRC_RESET = 32'd10;

	localparam logic [7:0] RTP_V2         = 8'h80;
	localparam logic [4:0] NAL_TYPE_SLICE = 5'd1;
	localparam logic [4:0] NAL_TYPE_IDR   = 5'd5;
	localparam logic [4:0] NAL_TYPE_FU_A  = 5'd28;

	// tuser bits of a result item
	localparam int TU_FRAG = 0;
	localparam int TU_ERR  = 1;

	// result tdata, header word in the lowest bits
	typedef struct packed {
		logic [4:0]        pad;
		logic [LEN_W-1:0]  len;
		logic [OFF_W-1:0]  off;
		logic [7:0]        fu;
		logic [7:0]        lead;
		logic [SSRC_W-1:0] ssrc;
		logic [TS_W-1:0]   ts;
		logic [31:0]       hdr;
	} out_data_t;

endpackage

/* hdl/h264_rtp_packetizer.sv */
// H.264 Annex B to RTP packet descriptor generator, top level.
// Depends on h264rtp_pkg.
`timescale 1ns / 1ps

// Usage
// - Input channel s_*: one Annex B byte per item; s_tlast marks the last byte of a
//   buffer. The buffer timestamp rides with every byte and is taken at byte 0.
// - Output channel m_*: one RTP packet descriptor per item (header word,
//   timestamp, SSRC, lead byte, FU header, payload offset and length); m_tlast
//   marks the final item of a unit, m_tuser flags fragment and oversize error.
// - Configuration: write cfg_wdata to register cfg_addr while cfg_we is high,
//   only while no unit is being turned into items.
// Timing
// - Bytes flow at one per cycle while the sequencer is idle.
// - A closing byte stalls the input while the sequencer walks the unit on its
//   one shared subtractor: SETUP for a single packet, SETUP and CHECK for an
//   oversize error, SETUP, CHECK and FRAG for fragments; more if m_tready is low.
// - The first item is loaded into the output register from SETUP for a single
//   packet, from CHECK for an oversize error and from FRAG for fragments.
// - The output register holds its item while m_tready is low; the next byte
//   is still taken when the sequencer is idle.
// Reset
// - arst_n clears the scanner, the sequence number and the output valid, and
//   loads the register defaults (payload limit 1400, type 96, SSRC 10).
module h264_rtp_packetizer #(
	parameter int BUFFER_BYTES  = h264rtp_pkg::DEF_BUFFER_BYTES,
	parameter int MAX_FRAGMENTS = h264rtp_pkg::DEF_MAX_FRAGMENTS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [h264rtp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [h264rtp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// data_byte [7:0], frame_timestamp [39:8]
	input  logic [h264rtp_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// header_word [31:0], timestamp_out [63:32], ssrc_out [95:64],
	// lead_byte [103:96], fu_header_byte [111:104], payload_offset [127:112],
	// payload_length [138:128], zero [143:139]
	output logic [h264rtp_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                                 m_tlast,
	// is_fragment [0], oversize_error [1]
	output logic [h264rtp_pkg::OUT_TUSER_W-1:0]  m_tuser
);
	import h264rtp_pkg::*;

	localparam int POS_W  = $clog2(BUFFER_BYTES);
	localparam int CNT_W  = $clog2(MAX_FRAGMENTS + 1);
	localparam int PROD_W = MP_W + CNT_W;
	localparam int SUB_W  = ((POS_W > PROD_W) ? POS_W : PROD_W) + 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUFFER_BYTES - 1);

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;
	localparam logic [1:0] ST_FRAG  = 2'd3;

	// configuration registers
	logic [MP_W-1:0]   max_payload_q;
	logic [PT_W-1:0]   payload_type_q;
	logic [SSRC_W-1:0] stream_ssrc_q;

	// start-code scanner
	logic [23:0]       recent_q;
	logic [POS_W-1:0]  pos_q;
	logic              inside_q;
	logic [POS_W-1:0]  unit_start_q;
	logic [7:0]        unit_header_q;
	logic              hdr_pend_q;
	logic              slice_q;
	logic [TS_W-1:0]   ts_q;

	// sequencer and its working registers
	logic [1:0]        state_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [POS_W-1:0]  em_start_q;
	logic [7:0]        em_header_q;
	logic [POS_W-1:0]  rem_q;
	logic [MP_W-1:0]   chunk_q;
	logic [PROD_W-1:0] prod_q;
	logic [OFF_W-1:0]  off_q;
	logic              first_q;

	// output register
	logic                   m_tvalid_q;
	out_data_t              out_data_q;
	logic                   out_last_q;
	logic [OUT_TUSER_W-1:0] out_user_q;

	logic [BYTE_W-1:0] in_byte;
	logic [TS_W-1:0]   in_ts;
	logic              in_acc;
	logic              is_last;
	logic              is_code;
	logic              close_code;
	logic              close_last;
	logic [POS_W:0]    len_code;
	logic [POS_W:0]    len_last;
	logic [POS_W-1:0]  unit_len;
	logic              emit_go;

	logic [MP_W-1:0]   mp_clamp;
	logic [MP_W-1:0]   chunk_next;
	logic [PROD_W-1:0] prod_next;
	logic [OFF_W-1:0]  first_off;
	logic [SUB_W-1:0]  sub_a;
	logic [SUB_W-1:0]  sub_b;
	logic [SUB_W-1:0]  sub_d;
	logic              sub_neg;
	logic              sub_zero;
	logic              out_free;
	logic              frag_last;
	logic [LEN_W-1:0]  piece;
	logic              ld_single;
	logic              ld_error;
	logic              ld_frag;
	logic              ld_any;
	logic [SEQ_W-1:0]  seq_next;
	out_data_t              out_next;
	logic                   out_last_next;
	logic [OUT_TUSER_W-1:0] out_user_next;

	assign in_byte = s_tdata[BYTE_W-1:0];
	assign in_ts   = s_tdata[BYTE_W +: TS_W];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc  = s_tvalid & s_tready;

	// A byte at the last buffer index counts as the end of the buffer.
	assign is_last = s_tlast | (pos_q >= POS_LAST);
	assign is_code = (recent_q == '0) & (in_byte == 8'h01);

	// A start code ends an open non-slice unit; the end of the buffer ends
	// whatever unit is still open, the one whose header byte this is included.
	assign close_code = ~hdr_pend_q & is_code & inside_q & ~slice_q;
	assign close_last = is_last & inside_q & ~close_code;

	assign len_code = {1'b0, pos_q} - (POS_W+1)'(3) - {1'b0, unit_start_q};
	assign len_last = {1'b0, pos_q} + (POS_W+1)'(1) - {1'b0, unit_start_q};
	assign unit_len = close_code ? len_code[POS_W-1:0] : len_last[POS_W-1:0];

	// An empty unit (start code over its header byte) gives nothing.
	assign emit_go = in_acc & (close_code | close_last) & (unit_len != '0);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q  <= MP_RESET;
			payload_type_q <= PT_RESET;
			stream_ssrc_q  <= SSRC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MAX_PAYLOAD:  max_payload_q  <= cfg_wdata[MP_W-1:0];
				REG_PAYLOAD_TYPE: payload_type_q <= cfg_wdata[PT_W-1:0];
				REG_STREAM_SSRC:  stream_ssrc_q  <= cfg_wdata[SSRC_W-1:0];
				default: ;
			endcase
		end
	end

	// Scanner: track the last three bytes, the buffer position and the open unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q      <= '1;
			pos_q         <= '0;
			inside_q      <= 1'b0;
			unit_start_q  <= '0;
			unit_header_q <= '0;
			hdr_pend_q    <= 1'b0;
			slice_q       <= 1'b0;
			ts_q          <= '0;
		end else if (in_acc) begin
			if (pos_q == '0) begin
				ts_q <= in_ts;
			end
			if (hdr_pend_q) begin
				// Slices run to the end of the buffer.
				unit_header_q <= in_byte;
				slice_q       <= (in_byte[4:0] == NAL_TYPE_SLICE) ||
				                 (in_byte[4:0] == NAL_TYPE_IDR);
			end
			if (is_last) begin
				inside_q   <= 1'b0;
				hdr_pend_q <= 1'b0;
				recent_q   <= '1;
				pos_q      <= '0;
			end else begin
				if (hdr_pend_q) begin
					hdr_pend_q <= 1'b0;
				end else if (is_code && (!inside_q || !slice_q)) begin
					// Open a unit unless a slice swallows the start code; a
					// start code that closes a unit opens the next at once.
					unit_start_q <= pos_q + POS_W'(1);
					inside_q     <= 1'b1;
					hdr_pend_q   <= 1'b1;
				end
				recent_q <= {recent_q[15:0], in_byte};
				pos_q    <= pos_q + POS_W'(1);
			end
		end
	end

	// Clamp the payload limit into its legal range.
	always_comb begin
		priority if (max_payload_q < MP_MIN) begin
			mp_clamp = MP_MIN;
		end else if (max_payload_q > MP_MAX) begin
			mp_clamp = MP_MAX;
		end else begin
			mp_clamp = max_payload_q;
		end
	end

	assign chunk_next = mp_clamp - MP_W'(2);
	assign prod_next  = PROD_W'(chunk_next) * PROD_W'(MAX_FRAGMENTS);
	assign first_off  = OFF_W'((POS_W+1)'(em_start_q) + (POS_W+1)'(1));

	// Shared subtractor: remaining bytes against the payload limit (single or
	// not), the fragment budget (oversize or not) and one fragment (last or not).
	always_comb begin
		sub_a = SUB_W'(rem_q);
		unique case (state_q)
			ST_SETUP:         sub_b = SUB_W'(mp_clamp);
			ST_CHECK:         sub_b = SUB_W'(prod_q);
			ST_IDLE, ST_FRAG: sub_b = SUB_W'(chunk_q);
		endcase
	end

	assign sub_d    = sub_a - sub_b;
	assign sub_neg  = sub_d[SUB_W-1];
	assign sub_zero = (sub_d == '0);

	assign out_free  = ~m_tvalid_q | m_tready;
	assign frag_last = sub_neg | sub_zero;
	assign piece     = frag_last ? LEN_W'(rem_q) : chunk_q;

	assign ld_single = (state_q == ST_SETUP) & sub_neg & out_free;
	assign ld_error  = (state_q == ST_CHECK) & ~sub_neg & ~sub_zero & out_free;
	assign ld_frag   = (state_q == ST_FRAG) & out_free;
	assign ld_any    = ld_single | ld_error | ld_frag;
	assign seq_next  = seq_q + SEQ_W'(1);

	// Result assembly
	always_comb begin
		out_next      = '0;
		out_next.ts   = ts_q;
		out_next.ssrc = stream_ssrc_q;
		out_last_next = 1'b1;
		out_user_next = '0;
		unique case (state_q)
			ST_CHECK: begin
				// oversize: no packet, sequence number untouched
				out_next.lead          = em_header_q;
				out_next.off           = OFF_W'(em_start_q);
				out_user_next[TU_ERR]  = 1'b1;
			end
			ST_FRAG: begin
				out_next.hdr           = {RTP_V2, frag_last, payload_type_q, seq_next};
				out_next.lead          = {em_header_q[7:5], NAL_TYPE_FU_A};
				out_next.fu            = {first_q, frag_last, 1'b0, em_header_q[4:0]};
				out_next.off           = off_q;
				out_next.len           = piece;
				out_last_next          = frag_last;
				out_user_next[TU_FRAG] = 1'b1;
			end
			ST_IDLE, ST_SETUP: begin
				out_next.hdr  = {RTP_V2, 1'b1, payload_type_q, seq_next};
				out_next.lead = em_header_q;
				out_next.off  = first_off;
				out_next.len  = LEN_W'(rem_q);
			end
		endcase
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			seq_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ld_any) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (ld_single || ld_frag) begin
				seq_q <= seq_next;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (emit_go) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					// hold here until the single packet finds the output free
					if (!sub_neg) begin
						state_q <= ST_CHECK;
					end else if (ld_single) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CHECK: begin
					if (!sub_neg && !sub_zero) begin
						if (ld_error) begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_FRAG;
					end
				end
				ST_FRAG: begin
					if (ld_frag && frag_last) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Sequencer datapath
	always_ff @(posedge clk) begin
		if (emit_go) begin
			em_start_q  <= unit_start_q;
			em_header_q <= hdr_pend_q ? in_byte : unit_header_q;
			rem_q       <= unit_len - POS_W'(1);
		end
		if (state_q == ST_SETUP) begin
			chunk_q <= chunk_next;
			prod_q  <= prod_next;
			off_q   <= first_off;
			first_q <= 1'b1;
		end
		if (ld_frag) begin
			first_q <= 1'b0;
			off_q   <= off_q + OFF_W'(piece);
			rem_q   <= sub_d[POS_W-1:0];
		end
		if (ld_any) begin
			out_data_q <= out_next;
			out_last_q <= out_last_next;
			out_user_q <= out_user_next;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_user_q;

endmodule

/* hdl/h264rtp_checker.sv */
// Port-level checker for the H.264 RTP packetizer, bound to the top level.
// Depends on h264rtp_pkg and h264_rtp_packetizer_macros.svh.
`timescale 1ns / 1ps
`include "h264_rtp_packetizer_macros.svh"

module h264rtp_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [h264rtp_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                                m_tlast,
	input logic [h264rtp_pkg::OUT_TUSER_W-1:0] m_tuser
);
	import h264rtp_pkg::*;

	out_data_t od;

	assign od = out_data_t'(m_tdata);

	// stalled item holds
	`RTP_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output item changed under stall")

	// oversize result closes the unit and carries no packet
	`RTP_ASSERT(a_err_shape, m_tvalid && m_tuser[TU_ERR] |-> m_tlast && !m_tuser[TU_FRAG] && od.hdr == 32'd0 && od.len == '0, "malformed oversize item")

	// single-unit packet always ends its unit with the marker set
	`RTP_ASSERT(a_single_shape, m_tvalid && !m_tuser[TU_FRAG] && !m_tuser[TU_ERR] |-> m_tlast && od.hdr[23] && od.hdr[31:24] == RTP_V2 && od.fu == 8'd0, "malformed single packet")

	// fragment: FU-A type, end bit and marker follow the last flag
	`RTP_ASSERT(a_frag_shape, m_tvalid && m_tuser[TU_FRAG] |-> od.lead[4:0] == NAL_TYPE_FU_A && od.fu[6] == m_tlast && od.hdr[23] == m_tlast && od.len != '0, "malformed fragment")

endmodule

bind h264_rtp_packetizer h264rtp_checker u_h264rtp_checker (.*);

/* sim/h264_rtp_packetizer_tb.sv */
// Self-checking bench for the H.264 RTP packetizer top level.
// Depends on h264rtp_pkg and h264_rtp_packetizer; a built-in packetizer model
// predicts every descriptor, which is compared field by field as it leaves.
`timescale 1ns / 1ps

module h264_rtp_packetizer_tb;

	import h264rtp_pkg::*;

	localparam int BUFFER_BYTES  = DEF_BUFFER_BYTES;
	localparam int MAX_FRAGMENTS = DEF_MAX_FRAGMENTS;
	// cycles to hold off after the last descriptor before touching registers
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BYTES_PER_PHASE = 20;
	localparam int PRINT_LIMIT = 50;

	// one descriptor as it leaves the block: tdata, tlast and tuser
	typedef struct packed {
		out_data_t                data;
		logic                     last;
		logic [OUT_TUSER_W-1:0]   user;
	} desc_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_ADDR_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic [OUT_TUSER_W-1:0] m_tuser;

	h264_rtp_packetizer #(
		.BUFFER_BYTES  (BUFFER_BYTES),
		.MAX_FRAGMENTS (MAX_FRAGMENTS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	// Register copies held by the model
	logic [MP_W-1:0]   cfg_max_payload;
	logic [PT_W-1:0]   cfg_payload_type;
	logic [SSRC_W-1:0] cfg_ssrc;

	// Scanner and packetizer state of the model
	logic [23:0]       scan_recent;
	int                scan_pos;
	logic              unit_open;
	int                unit_start;
	logic [7:0]        unit_hdr;
	logic              hdr_pending;
	logic              slice_unit;
	logic [SEQ_W-1:0]  rtp_seq;
	logic [TS_W-1:0]   frame_ts;

	desc_t      descs_due[$];
	logic [7:0] stream_bytes[$];

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int fault_count    = 0;
	int desc_count     = 0;
	int byte_count     = 0;
	int reg_writes     = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	task automatic report_fault(input string msg);
		fault_count++;
		if (fault_count <= PRINT_LIMIT)
			$display("ERROR %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_fault($sformatf("%s got %h want %h (descriptor %0d)", name, got, want,
				desc_count));
	endtask

	// ------------------------------------------------------------------
	// Packetizer model
	// ------------------------------------------------------------------

	// Advance the sequence number, then build the first RTP word
	function automatic logic [31:0] next_rtp_word(input logic marker);
		rtp_seq = rtp_seq + 16'd1;
		return {RTP_V2, marker, cfg_payload_type, rtp_seq};
	endfunction

	task automatic queue_desc(input logic [31:0] hdr, input logic [7:0] lead,
			input logic [7:0] fu, input logic frag, input int off, input int len,
			input logic last, input logic err);
		desc_t d;
		d.data.pad  = '0;
		d.data.len  = LEN_W'(len);
		d.data.off  = OFF_W'(off);
		d.data.fu   = fu;
		d.data.lead = lead;
		d.data.ssrc = cfg_ssrc;
		d.data.ts   = frame_ts;
		d.data.hdr  = hdr;
		d.last      = last;
		d.user      = '0;
		d.user[TU_FRAG] = frag;
		d.user[TU_ERR]  = err;
		descs_due.push_back(d);
	endtask

	// Turn a finished unit of unit_len bytes into descriptors
	task automatic packetize_unit(input int unit_len);
		int   mp;
		int   chunk;
		int   count;
		int   remain;
		int   off;
		int   piece;
		logic lastp;
		if (unit_len == 0)
			return;
		mp = cfg_max_payload;
		if (mp < MP_MIN)
			mp = MP_MIN;
		if (mp > MP_MAX)
			mp = MP_MAX;
		if (unit_len <= mp) begin
			queue_desc(next_rtp_word(1'b1), unit_hdr, 8'h00, 1'b0, unit_start + 1,
				unit_len - 1, 1'b1, 1'b0);
			return;
		end
		// the header byte is dropped; the rest goes out in FU-A pieces
		chunk = mp - 2;
		count = (unit_len - 1 + chunk - 1) / chunk;
		if (count > MAX_FRAGMENTS) begin
			queue_desc(32'h0, unit_hdr, 8'h00, 1'b0, unit_start, 0, 1'b1, 1'b1);
			return;
		end
		remain = unit_len - 1;
		off    = unit_start + 1;
		for (int k = 0; k < count; k++) begin
			piece = (remain < chunk) ? remain : chunk;
			lastp = (k + 1 == count);
			queue_desc(next_rtp_word(lastp), {unit_hdr[7:5], NAL_TYPE_FU_A},
				{(k == 0), lastp, 1'b0, unit_hdr[4:0]}, 1'b1, off, piece, lastp, 1'b0);
			off    += piece;
			remain -= piece;
		end
	endtask

	// Feed one accepted byte to the model
	task automatic scan_byte(input logic [7:0] b, input logic eob, input logic [31:0] ts);
		logic last_byte;
		logic code;
		last_byte = eob || (scan_pos >= BUFFER_BYTES - 1);
		code      = (scan_recent == 24'h0) && (b == 8'h01);
		if (scan_pos == 0)
			frame_ts = ts;
		if (hdr_pending) begin
			unit_hdr    = b;
			slice_unit  = (b[4:0] == NAL_TYPE_SLICE) || (b[4:0] == NAL_TYPE_IDR);
			hdr_pending = 1'b0;
		end else if (code) begin
			// a start code closes any unit except a slice
			if (unit_open && !slice_unit) begin
				packetize_unit(scan_pos - 3 - unit_start);
				unit_open = 1'b0;
			end
			if (!unit_open && !last_byte) begin
				unit_start  = scan_pos + 1;
				unit_open   = 1'b1;
				hdr_pending = 1'b1;
			end
		end
		if (last_byte) begin
			if (unit_open && !hdr_pending)
				packetize_unit(scan_pos + 1 - unit_start);
			unit_open   = 1'b0;
			hdr_pending = 1'b0;
			scan_recent = 24'hFFFFFF;
			scan_pos    = 0;
		end else begin
			scan_recent = {scan_recent[15:0], b};
			scan_pos++;
		end
	endtask

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Write one register; hold enable for a single edge
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MAX_PAYLOAD:  cfg_max_payload  = value[MP_W-1:0];
			REG_PAYLOAD_TYPE: cfg_payload_type = value[PT_W-1:0];
			REG_STREAM_SSRC:  cfg_ssrc         = value[SSRC_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// Offer one byte, idling first at random; leave tvalid high on return
	task automatic send_byte(input logic [7:0] b, input logic eob);
		logic [31:0] ts;
		ts = $urandom;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {ts, b};
		s_tlast  <= eob;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		scan_byte(b, eob, ts);
		byte_count++;
	endtask

	// Send the assembled bytes as one buffer, tlast on the final byte if asked
	task automatic send_stream(input logic close);
		foreach (stream_bytes[i])
			send_byte(stream_bytes[i], close && (i == stream_bytes.size() - 1));
		stream_bytes.delete();
	endtask

	// Append a start code and a unit of total_len bytes, header first
	task automatic add_unit(input logic [7:0] hdr, input int total_len, input logic zero_heavy);
		int r;
		stream_bytes.push_back(8'h00);
		stream_bytes.push_back(8'h00);
		stream_bytes.push_back(8'h00);
		stream_bytes.push_back(8'h01);
		stream_bytes.push_back(hdr);
		repeat (total_len - 1) begin
			r = $urandom_range(3);
			if (!zero_heavy)
				stream_bytes.push_back(8'($urandom_range(2, 255)));
			else if (r < 2)
				stream_bytes.push_back(8'h00);
			else if (r == 2)
				stream_bytes.push_back(8'h01);
			else
				stream_bytes.push_back(8'($urandom));
		end
	endtask

	// Drop tvalid, wait for every due descriptor, then let the block go idle
	task automatic settle();
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;
		@(posedge clk);
		while (descs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Check every descriptor that is taken, then pick the next tready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_desc();
		m_tready <= arst_n && ($urandom_range(99) >= sink_stall_pct);
	end

	task automatic check_desc();
		out_data_t got;
		desc_t     want;
		got = m_tdata;
		if (descs_due.size() == 0) begin
			report_fault($sformatf("descriptor with nothing due: hdr %h off %0d len %0d",
				got.hdr, got.off, got.len));
			return;
		end
		want = descs_due.pop_front();
		desc_count++;
		check_field("header_word", got.hdr, want.data.hdr);
		check_field("timestamp_out", got.ts, want.data.ts);
		check_field("ssrc_out", got.ssrc, want.data.ssrc);
		check_field("lead_byte", 32'(got.lead), 32'(want.data.lead));
		check_field("fu_header_byte", 32'(got.fu), 32'(want.data.fu));
		check_field("payload_offset", 32'(got.off), 32'(want.data.off));
		check_field("payload_length", 32'(got.len), 32'(want.data.len));
		check_field("tdata padding", 32'(got.pad), 32'(want.data.pad));
		check_field("last_of_unit", 32'(m_tlast), 32'(want.last));
		check_field("is_fragment", 32'(m_tuser[TU_FRAG]), 32'(want.user[TU_FRAG]));
		check_field("oversize_error", 32'(m_tuser[TU_ERR]), 32'(want.user[TU_ERR]));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Default registers: stray bytes, two parameter units closed by start
	// codes, then an IDR slice that swallows a start code and ends the buffer
	task automatic test_reset_defaults();
		stream_bytes = {8'hAA, 8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h42, 8'h00, 8'h1F,
			8'h00, 8'h00, 8'h00, 8'h01, 8'h68, 8'hCE,
			8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h11, 8'h22,
			8'h00, 8'h00, 8'h00, 8'h01, 8'h33, 8'h44};
		send_stream(1'b1);
	endtask

	// Unit edges: unit at byte 0, empty unit, start code on the last byte,
	// header on the last byte, single-byte buffer, short start code, slice
	task automatic test_unit_boundaries();
		settle();
		write_reg(REG_MAX_PAYLOAD, 32'(MP_MAX));
		write_reg(REG_PAYLOAD_TYPE, 32'd127);
		write_reg(REG_STREAM_SSRC, 32'hFFFF_FFFF);
		stream_bytes = {8'h00, 8'h00, 8'h00, 8'h01, 8'h06, 8'hAB,
			8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h09, 8'hF0,
			8'h00, 8'h00, 8'h00, 8'h01};
		send_stream(1'b1);
		stream_bytes = {8'h00, 8'h00, 8'h00, 8'h01, 8'h0C};
		send_stream(1'b1);
		stream_bytes = {8'h55};
		send_stream(1'b1);
		stream_bytes = {8'h00, 8'h00, 8'h00, 8'h01};
		send_stream(1'b1);
		// three zeros are needed, so this opens nothing
		stream_bytes = {8'h7E, 8'h00, 8'h00, 8'h01, 8'h41, 8'h22};
		send_stream(1'b1);
		stream_bytes = {8'h00, 8'h00, 8'h00, 8'h01, 8'hE1, 8'h10,
			8'h00, 8'h00, 8'h00, 8'h01, 8'h21};
		send_stream(1'b1);
	endtask

	// Smallest payload limit: one-byte unit, exact fit and one byte over
	task automatic test_fragment_limits();
		settle();
		write_reg(REG_MAX_PAYLOAD, 32'(MP_MIN));
		write_reg(REG_PAYLOAD_TYPE, 32'($urandom_range(0, 127)));
		write_reg(REG_STREAM_SSRC, $urandom);
		add_unit(8'h06, 1, 1'b0);
		add_unit(8'h26, 16, 1'b0);
		add_unit(8'h46, 17, 1'b0);
		send_stream(1'b1);
	endtask

	// A limit of zero acts as 16; the largest write leaves short units whole
	task automatic test_payload_clamp();
		settle();
		write_reg(REG_MAX_PAYLOAD, 32'd0);
		add_unit(8'h0C, 17, 1'b0);
		send_stream(1'b1);
		settle();
		write_reg(REG_MAX_PAYLOAD, 32'd2047);
		add_unit(8'h08, 10, 1'b0);
		send_stream(1'b1);
	endtask

	// Random buffers of well-formed units with random content, plus noise
	// buffers and broken tails, under one idle mix and one register setting
	task automatic test_random_streams(input int src_pct, input int sink_pct,
			input logic [MP_W-1:0] mp, input logic [PT_W-1:0] pt, input logic [SSRC_W-1:0] ssrc);
		int         phase_bytes;
		int         cap;
		logic [7:0] hdr;
		settle();
		// junk above the register width must be dropped
		write_reg(REG_MAX_PAYLOAD, {21'($urandom), mp});
		write_reg(REG_PAYLOAD_TYPE, {25'($urandom), pt});
		write_reg(REG_STREAM_SSRC, ssrc);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		cap = (mp < 18) ? 2 * mp + 4 : 32;
		phase_bytes = 0;
		while (phase_bytes < RANDOM_BYTES_PER_PHASE) begin
			if ($urandom_range(7) == 0) begin
				repeat ($urandom_range(1, 8))
					stream_bytes.push_back(8'($urandom));
			end else begin
				repeat ($urandom_range(0, 2))
					stream_bytes.push_back(8'($urandom));
				repeat ($urandom_range(1, 2)) begin
					hdr = 8'($urandom);
					if ($urandom_range(3) == 0)
						hdr[4:0] = $urandom_range(1) ? NAL_TYPE_SLICE : NAL_TYPE_IDR;
					add_unit(hdr, $urandom_range(1, cap), $urandom_range(3) == 0);
				end
				// broken tails: bare start code, or start code plus header
				case ($urandom_range(5))
					0: begin
						stream_bytes.push_back(8'h00);
						stream_bytes.push_back(8'h00);
						stream_bytes.push_back(8'h00);
						stream_bytes.push_back(8'h01);
					end
					1: add_unit(8'($urandom), 1, 1'b0);
					default: ;
				endcase
			end
			phase_bytes += stream_bytes.size();
			send_stream(1'b1);
		end
		settle();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
	endtask

	initial begin
		cfg_max_payload  = MP_RESET;
		cfg_payload_type = PT_RESET;
		cfg_ssrc         = SSRC_RESET;
		scan_recent      = 24'hFFFFFF;
		scan_pos         = 0;
		unit_open        = 1'b0;
		unit_start       = 0;
		unit_hdr         = 8'h00;
		hdr_pending      = 1'b0;
		slice_unit       = 1'b0;
		rtp_seq          = '0;
		frame_ts         = '0;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_addr  <= '0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_unit_boundaries();
		test_fragment_limits();
		test_payload_clamp();
		test_random_streams(0, 0, MP_MIN, 7'd0, 32'h0);
		test_random_streams(67, 0, 11'($urandom_range(17, 40)), 7'($urandom), $urandom);
		test_random_streams(0, 67, 11'd24, 7'($urandom), $urandom);
		test_random_streams(33, 33, MP_MAX, 7'd127, 32'hFFFF_FFFF);
		settle();

		$display("Sent %0d bytes and checked %0d descriptors after %0d register writes,",
			byte_count, desc_count, reg_writes);
		$display("over unit edges, fragment splits, clamping and four idle mixes.");
		if (fault_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
